### hw/rtl/chip8_pkg.sv
// Shared types, constants and a helper function of the CHIP-8 core.
package chip8_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int SCR_AW      = $clog2(SCREEN_H);
  localparam int COL_AW      = $clog2(SCREEN_W);
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int FONT_BYTES  = 80;

  localparam logic [11:0] PC_RESET = 12'h200;

  typedef logic [MEM_AW-1:0] mem_addr_t;

  // item kinds
  localparam logic [2:0] KIND_EXEC     = 3'd0;
  localparam logic [2:0] KIND_TICK     = 3'd1;
  localparam logic [2:0] KIND_PRESS    = 3'd2;
  localparam logic [2:0] KIND_RELEASE  = 3'd3;
  localparam logic [2:0] KIND_WRITE    = 3'd4;
  localparam logic [2:0] KIND_RESTART  = 3'd5;
  localparam logic [2:0] KIND_READ_ROW = 3'd6;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_WAIT    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_RESET_VF  = 2'd0;
  localparam logic [1:0] REG_SHIFT_VY  = 2'd1;
  localparam logic [1:0] REG_BUMP_IDX  = 2'd2;
  localparam logic [1:0] REG_WRAP      = 2'd3;

  typedef enum logic [4:0] {
    STEP_IDLE, STEP_CLEAR, STEP_START, STEP_FETCH_HI, STEP_FETCH_LO, STEP_DECODE,
    STEP_RDX, STEP_RDY, STEP_RDW, STEP_EXEC, STEP_DRAW_RD, STEP_DRAW_WR, STEP_BCD,
    STEP_STORE_RD, STEP_STORE_WR, STEP_LOAD_RD, STEP_LOAD_WR, STEP_FINISH
  } step_t;

  typedef enum logic [2:0] {CL_SIMPLE, CL_DRAW, CL_BCD, CL_STORE, CL_LOAD} op_class_t;

  typedef struct packed {
    logic reset_vf_on_logic;
    logic shift_uses_vy;
    logic load_store_bumps_index;
    logic screen_wrap;
  } cfg_t;

  typedef struct packed {
    step_t     step;
    logic      take;
    logic [3:0] cnt;
    mem_addr_t clr_addr;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       key_wait;
    logic       op_zero;
    op_class_t  op_class;
    logic [3:0] n;
    logic [3:0] x;
  } stat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] mem_address;
    logic [7:0]  data_byte;
    logic [3:0]  key_number;
    logic [7:0]  random_byte;
    logic [4:0]  row_select;
  } item_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] index_value;
    logic [1:0]  status;
    logic [7:0]  flag_register;
    logic        sound_on;
    logic [63:0] screen_row_bits;
  } rsp_t;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // power-up contents of main memory: glyphs at the bottom, zero above
  function automatic logic [7:0] font_byte(mem_addr_t a);
    logic [7:0] b;
    b = 8'h00;
    if (a < mem_addr_t'(FONT_BYTES)) b = FONT[a[6:0]];
    return b;
  endfunction

endpackage

### hw/rtl/chip8_if.sv
// Valid/ready channel interfaces for item and result beats.
interface chip8_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [11:0] mem_address;
  logic [7:0]  data_byte;
  logic [3:0]  key_number;
  logic [7:0]  random_byte;
  logic [4:0]  row_select;
  modport source (output valid, kind, mem_address, data_byte, key_number, random_byte,
                  row_select, input ready);
  modport sink (input valid, kind, mem_address, data_byte, key_number, random_byte,
                row_select, output ready);
endinterface

interface chip8_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter;
  logic [15:0] index_value;
  logic [1:0]  status;
  logic [7:0]  flag_register;
  logic        sound_on;
  logic [63:0] screen_row_bits;
  modport source (output valid, program_counter, index_value, status, flag_register,
                  sound_on, screen_row_bits, input ready);
  modport sink (input valid, program_counter, index_value, status, flag_register,
                sound_on, screen_row_bits, output ready);
endinterface

### hw/rtl/chip8_ctrl.sv
// Sequencer of the CHIP-8 core: steps each item through the datapath.
module chip8_ctrl
  import chip8_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START, S_FETCH_HI, S_FETCH_LO, S_DECODE, S_RDX, S_RDY, S_RDW,
    S_EXEC, S_DRAW_RD, S_DRAW_WR, S_BCD, S_STORE_RD, S_STORE_WR, S_LOAD_RD, S_LOAD_WR,
    S_FINISH
  } state_t;

  state_t     state;
  logic [3:0] cnt;
  mem_addr_t  clr_addr;
  logic       fin_go;

  assign in_ready = (state == S_IDLE);
  assign fin_go   = (state == S_FINISH) && (!out_valid || out_ready);

  always_comb begin
    cmd.take     = in_valid && in_ready;
    cmd.cnt      = cnt;
    cmd.clr_addr = clr_addr;
    case (state)
      S_CLEAR:    cmd.step = STEP_CLEAR;
      S_START:    cmd.step = STEP_START;
      S_FETCH_HI: cmd.step = STEP_FETCH_HI;
      S_FETCH_LO: cmd.step = STEP_FETCH_LO;
      S_DECODE:   cmd.step = STEP_DECODE;
      S_RDX:      cmd.step = STEP_RDX;
      S_RDY:      cmd.step = STEP_RDY;
      S_RDW:      cmd.step = STEP_RDW;
      S_EXEC:     cmd.step = STEP_EXEC;
      S_DRAW_RD:  cmd.step = STEP_DRAW_RD;
      S_DRAW_WR:  cmd.step = STEP_DRAW_WR;
      S_BCD:      cmd.step = STEP_BCD;
      S_STORE_RD: cmd.step = STEP_STORE_RD;
      S_STORE_WR: cmd.step = STEP_STORE_WR;
      S_LOAD_RD:  cmd.step = STEP_LOAD_RD;
      S_LOAD_WR:  cmd.step = STEP_LOAD_WR;
      S_FINISH:   cmd.step = fin_go ? STEP_FINISH : STEP_IDLE;
      default:    cmd.step = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE:     if (in_valid) state <= S_START;
        S_START: begin
          if (stat.kind == KIND_EXEC && !stat.key_wait) state <= S_FETCH_HI;
          else state <= S_FINISH;
        end
        S_FETCH_HI: state <= S_FETCH_LO;
        S_FETCH_LO: state <= S_DECODE;
        S_DECODE:   state <= S_RDX;
        S_RDX:      state <= stat.op_zero ? S_FINISH : S_RDY;
        S_RDY:      state <= S_RDW;
        S_RDW:      state <= S_EXEC;
        S_EXEC: begin
          cnt <= '0;
          case (stat.op_class)
            CL_DRAW:  state <= (stat.n == 4'd0) ? S_FINISH : S_DRAW_RD;
            CL_BCD:   state <= S_BCD;
            CL_STORE: state <= S_STORE_RD;
            CL_LOAD:  state <= S_LOAD_RD;
            default:  state <= S_FINISH;
          endcase
        end
        S_DRAW_RD:  state <= S_DRAW_WR;
        S_DRAW_WR: begin
          cnt   <= cnt + 4'd1;
          state <= (cnt == stat.n - 4'd1) ? S_FINISH : S_DRAW_RD;
        end
        S_BCD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd2) state <= S_FINISH;
        end
        S_STORE_RD: state <= S_STORE_WR;
        S_STORE_WR: begin
          cnt   <= cnt + 4'd1;
          state <= (cnt == stat.x) ? S_FINISH : S_STORE_RD;
        end
        S_LOAD_RD:  state <= S_LOAD_WR;
        S_LOAD_WR: begin
          cnt   <= cnt + 4'd1;
          state <= (cnt == stat.x) ? S_FINISH : S_LOAD_RD;
        end
        S_FINISH: begin
          if (fin_go) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/chip8_dp.sv
// Datapath of the CHIP-8 core: memory, screen, registers and instruction logic.
module chip8_dp
  import chip8_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  cmd_t  cmd,
  input  item_t item_in,
  output stat_t stat,
  output rsp_t  rsp
);

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  mem_rdata;
  logic [63:0] scr [SCREEN_H];
  logic [63:0] scr_rd;
  logic        scr_rv;
  logic [SCREEN_H-1:0] scr_valid;
  logic [7:0]  v [16];
  logic [7:0]  rf_rdata;
  logic [11:0] stack [STACK_DEPTH];
  logic [SP_W-1:0] sp;
  logic [11:0] pc;
  logic [15:0] index;
  logic [7:0]  delay, sound;
  logic [15:0] key_mask;
  logic        key_wait;
  logic [3:0]  wait_target;
  item_t       item;
  logic [7:0]  op_hi, op_lo, vx, vy;
  logic [1:0]  status;

  logic [15:0] opcode;
  logic [3:0]  top, x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn, pc2, pc4;
  logic [8:0]  sum;
  logic [7:0]  sh;
  logic [15:0] idx_sum, idx_bump, idx_cnt;
  logic        key_dn;

  mem_addr_t   mem_raddr, mem_waddr;
  logic        mem_we;
  logic [7:0]  mem_wdata;
  logic [3:0]  rf_raddr;
  logic [SCR_AW-1:0] scr_raddr, dy_idx;
  logic [7:0]  dy8;
  logic        row_ok, hit;
  logic [63:0] mask, cur_row;
  logic [7:0]  hund, rem, tens, ones;
  logic [15:0] tens_prod;
  op_class_t   op_class;

  assign opcode   = {op_hi, op_lo};
  assign top      = opcode[15:12];
  assign x        = opcode[11:8];
  assign y        = opcode[7:4];
  assign n        = opcode[3:0];
  assign nn       = opcode[7:0];
  assign nnn      = opcode[11:0];
  assign pc2      = pc + 12'd2;
  assign pc4      = pc + 12'd4;
  assign sum      = {1'b0, vx} + {1'b0, vy};
  assign sh       = cfg.shift_uses_vy ? vy : vx;
  assign idx_sum  = index + {8'h00, vx};
  assign idx_bump = index + {12'h000, x} + 16'd1;
  assign idx_cnt  = index + {12'h000, cmd.cnt};
  assign key_dn   = (vx < 8'd16) && key_mask[vx[3:0]];

  always_comb begin
    op_class = CL_SIMPLE;
    if (top == 4'hD) op_class = CL_DRAW;
    else if (top == 4'hF) begin
      if (nn == 8'h33) op_class = CL_BCD;
      else if (nn == 8'h55) op_class = CL_STORE;
      else if (nn == 8'h65) op_class = CL_LOAD;
    end
  end

  assign stat.kind     = item.kind;
  assign stat.key_wait = key_wait;
  assign stat.op_zero  = (opcode == 16'h0000);
  assign stat.op_class = op_class;
  assign stat.n        = n;
  assign stat.x        = x;

  // sprite row placement for the current draw row
  assign dy8    = vy + {4'h0, cmd.cnt};
  assign row_ok = cfg.screen_wrap || (dy8 < 8'(SCREEN_H));
  assign dy_idx = dy8[SCR_AW-1:0];

  always_comb begin
    logic [7:0]        dx8;
    logic [COL_AW-1:0] dxi;
    mask = '0;
    for (int c = 0; c < 8; c++) begin
      dx8 = vx + 8'(c);
      dxi = dx8[COL_AW-1:0];
      if (mem_rdata[7-c] && (cfg.screen_wrap || dx8 < 8'(SCREEN_W))) mask[~dxi] = 1'b1;
    end
  end

  assign cur_row = scr_rv ? scr_rd : '0;
  assign hit     = |(cur_row & mask);

  // decimal digits of Vx
  always_comb begin
    if (vx >= 8'd200) hund = 8'd2;
    else if (vx >= 8'd100) hund = 8'd1;
    else hund = 8'd0;
    rem       = vx - 8'((hund * 8'd100));
    tens_prod = {8'h00, rem} * 16'd205;
    tens      = 8'(tens_prod >> 11);
    ones      = rem - 8'(tens * 8'd10);
  end

  always_comb begin
    case (cmd.step)
      STEP_FETCH_HI: mem_raddr = mem_addr_t'(pc);
      STEP_FETCH_LO: mem_raddr = mem_addr_t'(pc) + 1'b1;
      STEP_DRAW_RD,
      STEP_LOAD_RD:  mem_raddr = mem_addr_t'(idx_cnt);
      default:       mem_raddr = mem_addr_t'(pc);
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mem_addr_t'(idx_cnt);
    mem_wdata = rf_rdata;
    case (cmd.step)
      STEP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cmd.clr_addr;
        mem_wdata = font_byte(cmd.clr_addr);
      end
      STEP_START: begin
        mem_we    = (item.kind == KIND_WRITE);
        mem_waddr = mem_addr_t'(item.mem_address);
        mem_wdata = item.data_byte;
      end
      STEP_BCD: begin
        mem_we = 1'b1;
        if (cmd.cnt == 4'd0) mem_wdata = hund;
        else if (cmd.cnt == 4'd1) mem_wdata = tens;
        else mem_wdata = ones;
      end
      STEP_STORE_WR: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.step)
      STEP_RDX:      rf_raddr = (top == 4'hB) ? 4'h0 : x;
      STEP_RDY:      rf_raddr = y;
      STEP_STORE_RD: rf_raddr = cmd.cnt;
      default:       rf_raddr = x;
    endcase
  end

  assign scr_raddr = (cmd.step == STEP_DRAW_RD) ? dy_idx : item.row_select;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.step == STEP_DRAW_WR && row_ok) scr[dy_idx] <= cur_row ^ mask;
    scr_rd <= scr[scr_raddr];
  end

  always_ff @(posedge clk) begin
    rf_rdata <= v[rf_raddr];
    scr_rv   <= scr_valid[scr_raddr];
    if (rst) begin
      for (int i = 0; i < 16; i++) v[i] <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) stack[i] <= '0;
      sp          <= '0;
      pc          <= PC_RESET;
      index       <= '0;
      delay       <= '0;
      sound       <= '0;
      key_mask    <= '0;
      key_wait    <= 1'b0;
      wait_target <= '0;
      scr_valid   <= '0;
    end else begin
      if (cmd.take) item <= item_in;
      case (cmd.step)
        STEP_START: begin
          status <= ST_DONE;
          case (item.kind)
            KIND_EXEC: if (key_wait) status <= ST_WAIT;
            KIND_TICK: begin
              if (delay != 8'd0) delay <= delay - 8'd1;
              if (sound != 8'd0) sound <= sound - 8'd1;
            end
            KIND_PRESS: key_mask[item.key_number] <= 1'b1;
            KIND_RELEASE: begin
              if (key_wait) begin
                key_wait       <= 1'b0;
                v[wait_target] <= {4'h0, item.key_number};
              end
              key_mask[item.key_number] <= 1'b0;
            end
            KIND_RESTART: begin
              pc        <= PC_RESET;
              index     <= '0;
              scr_valid <= '0;
            end
            default: ;
          endcase
        end
        STEP_FETCH_LO: op_hi <= mem_rdata;
        STEP_DECODE:   op_lo <= mem_rdata;
        STEP_RDX:      if (opcode == 16'h0000) status <= ST_ZERO;
        STEP_RDY:      vx <= rf_rdata;
        STEP_RDW:      vy <= rf_rdata;
        STEP_EXEC: begin
          pc <= pc2;
          case (top)
            4'h0: begin
              if (nn == 8'hE0) scr_valid <= '0;
              else if (nn == 8'hEE) begin
                sp <= sp - 1'b1;
                pc <= stack[sp - 1'b1];
              end else if (nn != 8'hFA) status <= ST_INVALID;
            end
            4'h1: pc <= nnn;
            4'h2: begin
              stack[sp] <= pc2;
              sp        <= sp + 1'b1;
              pc        <= nnn;
            end
            4'h3: if (vx == nn) pc <= pc4;
            4'h4: if (vx != nn) pc <= pc4;
            4'h5: if (vx == vy) pc <= pc4;
            4'h6: v[x] <= nn;
            4'h7: v[x] <= vx + nn;
            4'h8: begin
              case (n)
                4'h0: v[x] <= vy;
                4'h1: begin
                  v[x] <= vx | vy;
                  if (cfg.reset_vf_on_logic) v[15] <= 8'h00;
                end
                4'h2: begin
                  v[x] <= vx & vy;
                  if (cfg.reset_vf_on_logic) v[15] <= 8'h00;
                end
                4'h3: begin
                  v[x] <= vx ^ vy;
                  if (cfg.reset_vf_on_logic) v[15] <= 8'h00;
                end
                4'h4: begin
                  v[x]  <= sum[7:0];
                  v[15] <= {7'h00, sum[8]};
                end
                4'h5: begin
                  v[x]  <= vx - vy;
                  v[15] <= {7'h00, vx > vy};
                end
                4'h6: begin
                  v[x]  <= {1'b0, sh[7:1]};
                  v[15] <= {7'h00, sh[0]};
                end
                4'h7: begin
                  v[x]  <= vy - vx;
                  v[15] <= {7'h00, vy > vx};
                end
                4'hE: begin
                  v[x]  <= {sh[6:0], 1'b0};
                  v[15] <= {7'h00, sh[7]};
                end
                default: status <= ST_INVALID;
              endcase
            end
            4'h9: if (vx != vy) pc <= pc4;
            4'hA: index <= {4'h0, nnn};
            4'hB: pc <= nnn + {4'h0, vx};
            4'hC: v[x] <= item.random_byte & nn;
            4'hD: v[15] <= 8'h00;
            4'hE: begin
              if (nn == 8'h9E) begin
                if (key_dn) pc <= pc4;
              end else if (nn == 8'hA1) begin
                if (!key_dn) pc <= pc4;
              end else status <= ST_INVALID;
            end
            default: begin
              case (nn)
                8'h07: v[x] <= delay;
                8'h0A: begin
                  key_wait    <= 1'b1;
                  wait_target <= x;
                  status      <= ST_WAIT;
                end
                8'h15: delay <= vx;
                8'h18: sound <= vx;
                8'h1E: begin
                  index <= idx_sum;
                  v[15] <= {7'h00, idx_sum > 16'h0FFF};
                end
                8'h29: index <= 16'({vx, 2'b00}) + 16'(vx);
                8'h33, 8'h55, 8'h65: ;
                default: status <= ST_INVALID;
              endcase
            end
          endcase
        end
        STEP_DRAW_WR: begin
          if (row_ok) begin
            scr_valid[dy_idx] <= 1'b1;
            if (hit) v[15] <= 8'h01;
          end
        end
        STEP_STORE_WR: begin
          if (cmd.cnt == x && cfg.load_store_bumps_index) index <= idx_bump;
        end
        STEP_LOAD_WR: begin
          v[cmd.cnt] <= mem_rdata;
          if (cmd.cnt == x && cfg.load_store_bumps_index) index <= idx_bump;
        end
        STEP_FINISH: begin
          rsp.program_counter <= pc;
          rsp.index_value     <= index;
          rsp.status          <= status;
          rsp.flag_register   <= v[15];
          rsp.sound_on        <= (sound != 8'd0);
          rsp.screen_row_bits <= (item.kind == KIND_READ_ROW) ? cur_row : '0;
        end
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/chip8_cpu_core.sv
// Top level of the CHIP-8 core: quirk registers, sequencer and datapath.
//
// Items arrive on in_ch and each one gives exactly one result beat on out_ch.
// Item kinds: execute one instruction, timer tick, key press, key release,
// memory byte write, program restart and screen row read.
// Quirk modes sit in four one-bit registers on the APB port at 0x0, 0x4,
// 0x8 and 0xC; write them only while no item is in flight.
// The core works on one item at a time, stepping it through a main memory with
// one read port and one write port. A non-execute item, or an execute while a
// key wait is pending, goes from its start step straight to its result. An
// execute fetches, decodes and reads its registers, stopping early on a zero
// opcode; a draw, register store or load, or decimal store then works through
// its sprite rows, registers or digits one at a time. After reset the core
// sweeps the main memory once, one byte a cycle, loading the glyphs and
// clearing the rest; in_ch stays not ready until the sweep ends.
// The result sits in an output register: the core takes the next item while
// a result waits, and holds the following result until the old one is taken.
module chip8_cpu_core
  import chip8_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  chip8_in_if.sink           in_ch,
  chip8_out_if.source        out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  rsp_t  rsp;
  item_t item_in;
  logic  ready_int;
  logic  valid_int;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_vf_on_logic      <= 1'b1;
      cfg.shift_uses_vy          <= 1'b1;
      cfg.load_store_bumps_index <= 1'b1;
      cfg.screen_wrap            <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_RESET_VF: cfg.reset_vf_on_logic      <= pwdata[0];
        REG_SHIFT_VY: cfg.shift_uses_vy          <= pwdata[0];
        REG_BUMP_IDX: cfg.load_store_bumps_index <= pwdata[0];
        REG_WRAP:     cfg.screen_wrap            <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RESET_VF: prdata = {31'h0, cfg.reset_vf_on_logic};
      REG_SHIFT_VY: prdata = {31'h0, cfg.shift_uses_vy};
      REG_BUMP_IDX: prdata = {31'h0, cfg.load_store_bumps_index};
      REG_WRAP:     prdata = {31'h0, cfg.screen_wrap};
      default:      prdata = '0;
    endcase
  end

  assign item_in.kind        = in_ch.kind;
  assign item_in.mem_address = in_ch.mem_address;
  assign item_in.data_byte   = in_ch.data_byte;
  assign item_in.key_number  = in_ch.key_number;
  assign item_in.random_byte = in_ch.random_byte;
  assign item_in.row_select  = in_ch.row_select;
  assign in_ch.ready         = ready_int;

  chip8_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (ready_int),
    .out_valid (valid_int),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  chip8_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .item_in (item_in),
    .stat    (stat),
    .rsp     (rsp)
  );

  assign out_ch.valid           = valid_int;
  assign out_ch.program_counter = rsp.program_counter;
  assign out_ch.index_value     = rsp.index_value;
  assign out_ch.status          = rsp.status;
  assign out_ch.flag_register   = rsp.flag_register;
  assign out_ch.sound_on        = rsp.sound_on;
  assign out_ch.screen_row_bits = rsp.screen_row_bits;

endmodule

### hw/rtl/chip8_checker.sv
// Port-level checks of the CHIP-8 core, bound to the top level.
module chip8_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_pc,
  input logic [1:0]  out_status,
  input logic [63:0] out_row
);

  logic [1:0] pending;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // items taken whose result beat has not gone out yet
  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else pending <= pending + {1'b0, in_beat} - {1'b0, out_beat};
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_pc) && $stable(out_status) && $stable(out_row))
    else $error("result payload changed while stalled");

  assert property (@(posedge clk) disable iff (rst) out_valid |-> pending != 2'd0)
    else $error("result beat without an item");

  assert property (@(posedge clk) disable iff (rst) pending != 2'd3)
    else $error("more than two items in flight");

  assert property (@(posedge clk) disable iff (rst) in_beat |=> !in_ready)
    else $error("item taken while one is still in work");

endmodule

bind chip8_cpu_core chip8_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_pc     (out_ch.program_counter),
  .out_status (out_ch.status),
  .out_row    (out_ch.screen_row_bits)
);
